FILE: rtl/tds_pkg.sv
// tds_pkg: shared types and constants for the table derivative stencil
// used by tds_stencil, tds_scale and table_derivative_stencil; no dependencies
package tds_pkg;

  // default widths of the sample path
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF    = 16;

  // fixed widths of the result and the step register
  localparam int SLOPE_W = 32;
  localparam int STEP_W  = 32;
  localparam int CNT_W   = 3;

  localparam logic [STEP_W-1:0] INV_STEP_RESET = 32'd65536;
  localparam logic [CNT_W-1:0]  CNT_SAT        = 3'd5;
  localparam logic [CNT_W-1:0]  CNT_FIRST_OUT  = 3'd3;
  localparam logic [CNT_W-1:0]  CNT_FULL       = 3'd4;

  // divide by three: q = (v * DIV3_MAGIC) >> DIV3_SHIFT, exact for v below 2^33
  localparam int              DIV3_IN_W  = 33;
  localparam int              DIV3_SHIFT = 33;
  localparam logic [31:0]     DIV3_MAGIC = 32'hAAAA_AAAB;

  // saturation thresholds on the value ahead of the divide by three
  localparam int              THR_W   = 34;
  localparam logic [THR_W-1:0] THR_POS = 34'h1_8000_0000;
  localparam logic [THR_W-1:0] THR_NEG = 34'h1_8000_0003;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = 32'h7FFF_FFFF;
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = 32'h8000_0000;

  // kind of derivative computed for one result item
  typedef enum logic [2:0] {
    JOB_FWD,
    JOB_CEN,
    JOB_BK3,
    JOB_BK4,
    JOB_SHORT
  } job_e;

  // control that travels with an item through the scaling pipeline
  typedef struct packed {
    logic is12;
    logic eor;
    logic sr;
  } tag_t;

  // results still owed for the current window
  typedef struct packed {
    logic shrt;
    logic fwd;
    logic cen;
    logic bk3;
    logic bk4;
  } pend_t;

endpackage

FILE: rtl/tds_cell.sv
// tds_cell: one sample cell of the sliding window
// takes its neighbor's sample on a shift; no package dependency
module tds_cell #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         shift_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] val_q;

  // window cells start at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

FILE: rtl/tds_stencil.sv
// tds_stencil: weighted sum of the five window cells for one result kind
// depends on tds_pkg (job_e, tag_t)
module tds_stencil #(
  parameter int SAMPLE_WIDTH = tds_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic signed [SAMPLE_WIDTH-1:0] w0_i,
  input  logic signed [SAMPLE_WIDTH-1:0] w1_i,
  input  logic signed [SAMPLE_WIDTH-1:0] w2_i,
  input  logic signed [SAMPLE_WIDTH-1:0] w3_i,
  input  logic signed [SAMPLE_WIDTH-1:0] w4_i,
  input  tds_pkg::job_e                  kind_i,
  output logic signed [SAMPLE_WIDTH+5:0] sum_o,
  output tds_pkg::tag_t                  tag_o
);
  import tds_pkg::*;

  localparam int SUM_W = SAMPLE_WIDTH + 6;

  localparam logic signed [SUM_W-1:0] C2  = SUM_W'(2);
  localparam logic signed [SUM_W-1:0] C8  = SUM_W'(8);
  localparam logic signed [SUM_W-1:0] C9  = SUM_W'(9);
  localparam logic signed [SUM_W-1:0] C11 = SUM_W'(11);
  localparam logic signed [SUM_W-1:0] C18 = SUM_W'(18);

  logic signed [SUM_W-1:0] e0, e1, e2, e3, e4;

  assign e0 = SUM_W'(w0_i);
  assign e1 = SUM_W'(w1_i);
  assign e2 = SUM_W'(w2_i);
  assign e3 = SUM_W'(w3_i);
  assign e4 = SUM_W'(w4_i);

  // stencil weights, w4 is the newest sample
  always_comb begin
    sum_o = '0;
    tag_o = '{is12: 1'b0, eor: 1'b0, sr: 1'b0};
    unique case (kind_i)
      JOB_FWD: sum_o = C18 * e2 + C2 * e4 - C11 * e1 - C9 * e3;
      JOB_CEN: begin
        sum_o      = e0 + C8 * e3 - C8 * e1 - e4;
        tag_o.is12 = 1'b1;
      end
      JOB_BK3: sum_o = C11 * e3 + C9 * e1 - C18 * e2 - C2 * e0;
      JOB_BK4: begin
        sum_o     = C11 * e4 + C9 * e2 - C18 * e3 - C2 * e1;
        tag_o.eor = 1'b1;
      end
      JOB_SHORT: begin
        sum_o     = '0;
        tag_o.eor = 1'b1;
        tag_o.sr  = 1'b1;
      end
      default: sum_o = '0;
    endcase
  end

endmodule

FILE: rtl/tds_scale.sv
// tds_scale: five-stage pipeline that scales a stencil sum by the reciprocal
// step, divides by 6 or 12 toward zero and saturates; depends on tds_pkg
module tds_scale #(
  parameter int SAMPLE_WIDTH = tds_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = tds_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tds_pkg::STEP_W-1:0]     inv_step_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH+5:0] sum_i,
  input  tds_pkg::tag_t                  tag_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tds_pkg::SLOPE_W-1:0]    slope_o,
  output tds_pkg::tag_t                  tag_o
);
  import tds_pkg::*;

  localparam int SUM_W   = SAMPLE_WIDTH + 6;
  localparam int ABS_W   = SAMPLE_WIDTH + 5;
  localparam int HI_W    = (ABS_W > 32) ? ABS_W - 32 : 1;
  localparam int ABS_PAD = 32 + HI_W;
  localparam int PW      = ABS_PAD + STEP_W;
  localparam int VW      = PW - FRAC_BITS - 1;
  localparam int CW      = (VW > THR_W) ? VW : THR_W;
  localparam int DW      = DIV3_IN_W + 32;

  // stage valids and advance enables
  logic [4:0] v_q;
  logic [4:0] en;

  assign en[4]      = !v_q[4] || out_ready_i;
  assign en[3]      = !v_q[3] || en[4];
  assign en[2]      = !v_q[2] || en[3];
  assign en[1]      = !v_q[1] || en[2];
  assign en[0]      = !v_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
    end
  end

  // stage 1: stencil sum
  logic signed [SUM_W-1:0] s1_sum_q;
  tag_t                    s1_tag_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_sum_q <= sum_i;
      s1_tag_q <= tag_i;
    end
  end

  // magnitude split in two partial products
  logic                 s1_neg;
  logic [SUM_W-1:0]     s1_mag;
  logic [ABS_PAD-1:0]   s1_abs;
  logic [63:0]          plo_d;
  logic [HI_W+31:0]     phi_d;

  assign s1_neg = s1_sum_q[SUM_W-1];
  assign s1_mag = s1_neg ? SUM_W'(-s1_sum_q) : SUM_W'(s1_sum_q);
  assign s1_abs = ABS_PAD'(s1_mag[ABS_W-1:0]);
  assign plo_d  = 64'(s1_abs[31:0]) * 64'(inv_step_i);
  assign phi_d  = (HI_W+32)'(s1_abs[ABS_PAD-1:32]) * (HI_W+32)'(inv_step_i);

  // stage 2: partial products
  logic [63:0]      s2_plo_q;
  logic [HI_W+31:0] s2_phi_q;
  logic             s2_neg_q;
  tag_t             s2_tag_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_plo_q <= plo_d;
      s2_phi_q <= phi_d;
      s2_neg_q <= s1_neg;
      s2_tag_q <= s1_tag_q;
    end
  end

  // full product, drop fraction and the power of two of the divisor
  logic [PW-1:0]        prod;
  logic [VW-1:0]        vq;
  logic [CW-1:0]        v_ext;
  logic [CW-1:0]        thr;
  logic                 sat_d;

  assign prod  = PW'(s2_plo_q) + {s2_phi_q, 32'b0};
  assign vq    = s2_tag_q.is12 ? VW'(prod >> (FRAC_BITS + 2)) : VW'(prod >> (FRAC_BITS + 1));
  assign v_ext = CW'(vq);
  assign thr   = s2_neg_q ? CW'(THR_NEG) : CW'(THR_POS);
  assign sat_d = v_ext >= thr;

  // stage 3: value ahead of the divide by three
  logic [DIV3_IN_W-1:0] s3_v_q;
  logic                 s3_sat_q;
  logic                 s3_neg_q;
  tag_t                 s3_tag_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_v_q   <= v_ext[DIV3_IN_W-1:0];
      s3_sat_q <= sat_d;
      s3_neg_q <= s2_neg_q;
      s3_tag_q <= s2_tag_q;
    end
  end

  // divide by three through the reciprocal
  logic [DW-1:0] div_prod;

  assign div_prod = DW'(s3_v_q) * DW'(DIV3_MAGIC);

  // stage 4: quotient
  logic [SLOPE_W-1:0] s4_q_q;
  logic               s4_sat_q;
  logic               s4_neg_q;
  tag_t               s4_tag_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_q_q   <= div_prod[DIV3_SHIFT+SLOPE_W-1:DIV3_SHIFT];
      s4_sat_q <= s3_sat_q;
      s4_neg_q <= s3_neg_q;
      s4_tag_q <= s3_tag_q;
    end
  end

  // saturate and restore the sign
  logic [SLOPE_W-1:0] mag;
  logic [SLOPE_W-1:0] slope_d;

  assign mag     = s4_sat_q ? (s4_neg_q ? SLOPE_MIN : SLOPE_MAX) : s4_q_q;
  assign slope_d = s4_neg_q ? SLOPE_W'(-mag) : mag;

  // stage 5: output register
  logic [SLOPE_W-1:0] s5_slope_q;
  tag_t               s5_tag_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_slope_q <= slope_d;
      s5_tag_q   <= s4_tag_q;
    end
  end

  assign out_valid_o = v_q[4];
  assign slope_o     = s5_slope_q;
  assign tag_o       = s5_tag_q;

endmodule

FILE: rtl/table_derivative_stencil.sv
// table_derivative_stencil: top level, window cells, result sequencer and
// step register; depends on tds_pkg, tds_cell, tds_stencil and tds_scale
//
// Streaming derivative of a table: one signed fixed-point sample per item,
// with last on the final sample. Every index of a run gets one slope item,
// in index order (forward difference at the first two, five-point central
// stencil inside, backward difference at the last two), scaled by inv_step
// and saturated to 32 bits. A run of fewer than five samples gives a single
// item with slope 0, end_of_run and short_run set. The window is a row of
// five sample cells; one shared five-stage scaling pipeline produces one
// result item per cycle unless out_ready_i holds it back. A sample is taken
// every cycle unless results are still owed: the fifth sample of a run owes
// two and a final sample of a run of five or more owes three or four, and
// the next sample waits until all are issued. The user writes inv_step
// through cfg_we_i / cfg_wdata_i while the block is idle; it is not enforced.
module table_derivative_stencil #(
  parameter int SAMPLE_WIDTH = tds_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = tds_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tds_pkg::STEP_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [tds_pkg::SLOPE_W-1:0] slope_o,
  output logic                           end_of_run_o,
  output logic                           short_run_o
);
  import tds_pkg::*;

  localparam int SUM_W = SAMPLE_WIDTH + 6;

  // step register
  logic [STEP_W-1:0] inv_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_step_q <= INV_STEP_RESET;
    end else if (cfg_we_i) begin
      inv_step_q <= cfg_wdata_i;
    end
  end

  logic accept;

  assign accept = in_valid_i && in_ready_o;

  // window cells, w4 takes the new sample and each hands to the older one
  logic signed [SAMPLE_WIDTH-1:0] w0, w1, w2, w3, w4;

  tds_cell #(.W(SAMPLE_WIDTH)) u_cell4 (
    .clk_i(clk_i), .rst_ni(rst_ni), .shift_i(accept), .d_i(sample_i), .q_o(w4)
  );
  tds_cell #(.W(SAMPLE_WIDTH)) u_cell3 (
    .clk_i(clk_i), .rst_ni(rst_ni), .shift_i(accept), .d_i(w4), .q_o(w3)
  );
  tds_cell #(.W(SAMPLE_WIDTH)) u_cell2 (
    .clk_i(clk_i), .rst_ni(rst_ni), .shift_i(accept), .d_i(w3), .q_o(w2)
  );
  tds_cell #(.W(SAMPLE_WIDTH)) u_cell1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .shift_i(accept), .d_i(w2), .q_o(w1)
  );
  tds_cell #(.W(SAMPLE_WIDTH)) u_cell0 (
    .clk_i(clk_i), .rst_ni(rst_ni), .shift_i(accept), .d_i(w1), .q_o(w0)
  );

  // sequencer state: samples seen and results owed
  logic [CNT_W-1:0] cnt_q, cnt_d;
  pend_t            pend_q, pend_d, pend_left, pend_new;
  job_e             kind;
  logic             iss_valid;
  logic             iss_ready;
  logic             iss_take;

  // pick the next owed result in index order
  always_comb begin
    pend_left = pend_q;
    iss_valid = pend_q != '0;
    kind      = JOB_FWD;
    priority if (pend_q.shrt) begin
      kind = JOB_SHORT;
    end else if (pend_q.fwd) begin
      kind = JOB_FWD;
    end else if (pend_q.cen) begin
      kind = JOB_CEN;
    end else if (pend_q.bk3) begin
      kind = JOB_BK3;
    end else begin
      kind = JOB_BK4;
    end
    iss_take = iss_valid && iss_ready;
    if (iss_take) begin
      unique case (kind)
        JOB_SHORT: pend_left.shrt = 1'b0;
        JOB_FWD:   pend_left.fwd  = 1'b0;
        JOB_CEN:   pend_left.cen  = 1'b0;
        JOB_BK3:   pend_left.bk3  = 1'b0;
        JOB_BK4:   pend_left.bk4  = 1'b0;
        default:   pend_left      = pend_q;
      endcase
    end
  end

  // a new item is taken once the window owes nothing after this cycle
  assign in_ready_o = pend_left == '0;

  // results owed by the item being taken
  always_comb begin
    pend_new = '0;
    if (last_i) begin
      if (cnt_q < CNT_FULL) begin
        pend_new.shrt = 1'b1;
      end else begin
        pend_new.fwd = cnt_q == CNT_FULL;
        pend_new.cen = 1'b1;
        pend_new.bk3 = 1'b1;
        pend_new.bk4 = 1'b1;
      end
    end else begin
      pend_new.fwd = (cnt_q == CNT_FIRST_OUT) || (cnt_q == CNT_FULL);
      pend_new.cen = cnt_q >= CNT_FULL;
    end
  end

  // next state of the sequencer
  always_comb begin
    pend_d = pend_left;
    cnt_d  = cnt_q;
    if (accept) begin
      pend_d = pend_new;
      if (last_i) begin
        cnt_d = '0;
      end else if (cnt_q != CNT_SAT) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  // stencil sum of the current window
  logic signed [SUM_W-1:0] sum;
  tag_t                    tag;

  tds_stencil #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_stencil (
    .w0_i   (w0),
    .w1_i   (w1),
    .w2_i   (w2),
    .w3_i   (w3),
    .w4_i   (w4),
    .kind_i (kind),
    .sum_o  (sum),
    .tag_o  (tag)
  );

  // scaling pipeline and output register
  logic [SLOPE_W-1:0] slope;
  tag_t               out_tag;

  tds_scale #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .inv_step_i  (inv_step_q),
    .in_valid_i  (iss_valid),
    .in_ready_o  (iss_ready),
    .sum_i       (sum),
    .tag_i       (tag),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .slope_o     (slope),
    .tag_o       (out_tag)
  );

  assign slope_o      = signed'(slope);
  assign end_of_run_o = out_tag.eor;
  assign short_run_o  = out_tag.sr;

endmodule
